### design/cfva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfva_pkg;

    localparam int LENGTH_BITS   = 16;
    localparam int TRAILER_BYTES = 4;
    localparam int FILL_W        = $clog2(TRAILER_BYTES + 1);
    localparam int DLY_IDX_W     = $clog2(TRAILER_BYTES);
    localparam int REPORT_W      = 16;
    localparam int LEN_EXT_W     = (LENGTH_BITS > REPORT_W) ? LENGTH_BITS : REPORT_W;

    localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
    localparam logic [7:0]  BYTE_MASK       = 8'hFF;
    localparam logic [REPORT_W-1:0] REPORT_MAX = {REPORT_W{1'b1}};
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_GOOD  = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;
    localparam logic [1:0] STATUS_SHORT = 2'd3;

    localparam logic MODE_APPEND   = 1'b0;
    localparam logic MODE_VALIDATE = 1'b1;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_TRAILER,
        TAIL_STATUS
    } tail_kind_t;

    // compact description of all results caused by one item
    typedef struct packed {
        logic                has_byte;
        logic [7:0]          first_byte;
        tail_kind_t          tail;
        logic [31:0]         crc_sum;
        logic [1:0]          status;
        logic [REPORT_W-1:0] length;
    } rslt_desc_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b & BYTE_MASK};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CASTAGNOLI_POLY : 32'd0);
        end
        return r;
    endfunction

    function automatic logic [REPORT_W-1:0] report_len(input logic [LENGTH_BITS-1:0] c);
        logic [LEN_EXT_W-1:0] ext;
        ext = LEN_EXT_W'(c);
        if (ext > LEN_EXT_W'(REPORT_MAX)) begin
            return REPORT_MAX;
        end
        return ext[REPORT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/cfva_core.sv
`timescale 1ns / 1ps
`default_nettype none

module cfva_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              mode,
    input  wire logic [7:0]        data_byte,
    input  wire logic              frame_last,
    output cfva_pkg::rslt_desc_t   desc,
    output logic                   desc_used
);
    import cfva_pkg::*;

    logic [31:0]            crc_reg, crc_next;
    logic [7:0]             dly_reg [TRAILER_BYTES];
    logic [7:0]             dly_next [TRAILER_BYTES];
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]            want;

    always_comb begin
        crc_next  = crc_reg;
        dly_next  = dly_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        want      = 32'd0;

        desc.has_byte   = 1'b0;
        desc.first_byte = 8'd0;
        desc.tail       = TAIL_NONE;
        desc.crc_sum    = 32'd0;
        desc.status     = STATUS_NONE;
        desc.length     = '0;

        if (mode == MODE_APPEND) begin
            crc_next = crc_fold(crc_reg, data_byte);
            if (cnt_reg != COUNT_MAX) begin
                cnt_next = cnt_reg + 1'b1;
            end
            desc.has_byte   = 1'b1;
            desc.first_byte = data_byte;
            if (frame_last) begin
                desc.tail    = TAIL_TRAILER;
                desc.crc_sum = ~crc_next;
                desc.length  = report_len(cnt_next);
            end
        end else begin
            if (fill_reg >= FILL_W'(TRAILER_BYTES)) begin
                // oldest held byte leaves as payload
                crc_next = crc_fold(crc_reg, dly_reg[0]);
                if (cnt_reg != COUNT_MAX) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                desc.has_byte   = 1'b1;
                desc.first_byte = dly_reg[0];
                for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
                    dly_next[i] = dly_reg[i + 1];
                end
                dly_next[TRAILER_BYTES - 1] = data_byte;
                fill_next = FILL_W'(TRAILER_BYTES);
            end else begin
                dly_next[fill_reg[DLY_IDX_W-1:0]] = data_byte;
                fill_next = fill_reg + 1'b1;
            end
            if (frame_last) begin
                desc.tail   = TAIL_STATUS;
                desc.length = report_len(cnt_next);
                if (fill_next < FILL_W'(TRAILER_BYTES)) begin
                    desc.status = STATUS_SHORT;
                end else begin
                    for (int i = 0; i < TRAILER_BYTES; i++) begin
                        want[8*i +: 8] = dly_next[i];
                    end
                    desc.status = (want == ~crc_next) ? STATUS_GOOD : STATUS_BAD;
                end
            end
        end

        if (frame_last) begin
            crc_next  = CRC_INIT;
            fill_next = '0;
            cnt_next  = '0;
            for (int i = 0; i < TRAILER_BYTES; i++) begin
                dly_next[i] = 8'd0;
            end
        end

        desc_used = desc.has_byte || (desc.tail != TAIL_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_INIT;
            fill_reg <= '0;
            cnt_reg  <= '0;
            for (int i = 0; i < TRAILER_BYTES; i++) begin
                dly_reg[i] <= 8'd0;
            end
        end else if (step) begin
            crc_reg  <= crc_next;
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
            dly_reg  <= dly_next;
        end
    end

endmodule

`default_nettype wire

### design/cfva_out_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module cfva_out_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire cfva_pkg::rslt_desc_t          desc_in,
    output logic                               take_ok,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_byte_present,
    output logic                               m_end_of_frame,
    output logic [1:0]                         m_check_status,
    output logic [cfva_pkg::REPORT_W-1:0]      m_payload_length
);
    import cfva_pkg::*;

    rslt_desc_t desc_reg;
    logic       vld_reg;
    logic [2:0] idx_reg;
    logic [2:0] n_res;
    logic [2:0] tail_idx;
    logic       last_res;

    always_comb begin
        case (desc_reg.tail)
            TAIL_TRAILER: n_res = {2'd0, desc_reg.has_byte} + 3'(TRAILER_BYTES);
            TAIL_STATUS:  n_res = {2'd0, desc_reg.has_byte} + 3'd1;
            default:      n_res = {2'd0, desc_reg.has_byte};
        endcase
    end

    assign last_res = (idx_reg == n_res - 3'd1);
    assign take_ok  = !vld_reg || (m_ready && last_res);
    assign m_valid  = vld_reg;
    assign tail_idx = idx_reg - {2'd0, desc_reg.has_byte};

    always_comb begin
        m_out_byte       = 8'd0;
        m_byte_present   = 1'b0;
        m_end_of_frame   = 1'b0;
        m_check_status   = STATUS_NONE;
        m_payload_length = '0;
        if (desc_reg.has_byte && idx_reg == 3'd0) begin
            m_out_byte     = desc_reg.first_byte;
            m_byte_present = 1'b1;
        end else begin
            case (desc_reg.tail)
                TAIL_TRAILER: begin
                    // trailer goes out least significant byte first
                    m_out_byte     = desc_reg.crc_sum[8*tail_idx[DLY_IDX_W-1:0] +: 8];
                    m_byte_present = 1'b1;
                    if (tail_idx == 3'(TRAILER_BYTES - 1)) begin
                        m_end_of_frame   = 1'b1;
                        m_payload_length = desc_reg.length;
                    end
                end
                TAIL_STATUS: begin
                    m_end_of_frame   = 1'b1;
                    m_check_status   = desc_reg.status;
                    m_payload_length = desc_reg.length;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= 3'd0;
        end else if (load) begin
            vld_reg <= 1'b1;
            idx_reg <= 3'd0;
        end else if (vld_reg && m_ready) begin
            if (last_res) begin
                vld_reg <= 1'b0;
                idx_reg <= 3'd0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= desc_in;
        end
    end

endmodule

`default_nettype wire

### design/crc32c_frame_append_validate_core.sv
`timescale 1ns / 1ps
`default_nettype none

// an item reaches the m_ outputs via the input register, then the result register
// one item per cycle unless the output sequencer is busy; an item with n results
//   holds it until all are taken (5 for append frame end, up to 2 in validate mode)
// the byte-wide crc update sits between the input register and the result register
// reset: synchronous active-low aresetn clears crc, delay line, counts and frame_mode
module crc32c_frame_append_validate_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_present,
    output logic             m_end_of_frame,
    output logic [1:0]       m_check_status,
    output logic [15:0]      m_payload_length
);
    import cfva_pkg::*;

    localparam logic REG_FRAME_MODE = 1'b0;

    logic       frame_mode_reg;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       step;
    logic       load;
    logic       take_ok;
    logic       desc_used;
    rslt_desc_t desc;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_MODE) ? {31'd0, frame_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg <= MODE_APPEND;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_MODE) begin
            frame_mode_reg <= pwdata[0];
        end
    end

    // items that cause no result need not wait for the output side
    assign step    = in_vld_reg && (take_ok || !desc_used);
    assign load    = step && desc_used;
    assign s_ready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (step) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_frame_last;
        end
    end

    cfva_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .mode       (frame_mode_reg),
        .data_byte  (in_byte_reg),
        .frame_last (in_last_reg),
        .desc       (desc),
        .desc_used  (desc_used)
    );

    cfva_out_seq u_out_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load),
        .desc_in          (desc),
        .take_ok          (take_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_present   (m_byte_present),
        .m_end_of_frame   (m_end_of_frame),
        .m_check_status   (m_check_status),
        .m_payload_length (m_payload_length)
    );

endmodule

`default_nettype wire
